FILE: hdl/spse_pkg.sv
// package with constants and types of the step pulse symbol encoder
`timescale 1ns / 1ps

package spse_pkg;

	localparam int unsigned PULSE_HIGH_LEN    = 2;
	localparam int unsigned HALF_DURATION_MAX = 32767;
	localparam int unsigned PERIOD_MAX        = PULSE_HIGH_LEN + HALF_DURATION_MAX * 127;

	localparam int unsigned PERIOD_W = 22;
	localparam int unsigned DUR_W    = 15;
	localparam int unsigned COUNT_W  = 16;

	localparam int unsigned S_TDATA_W = 24;
	localparam int unsigned M_TDATA_W = 48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHORT,
		ST_PULSE,
		ST_BULK
	} state_t;

endpackage

FILE: hdl/step_pulse_symbol_encoder_unit.sv
// top level of the step pulse symbol encoder
`timescale 1ns / 1ps

// Takes one step request (period in 1 us ticks) and sends out its pulse-train
// symbols, one per cycle while the sink keeps tready high, through a registered
// output stage. A step gives up to 64 symbols, and s_tready rises again the
// cycle after the last symbol is produced. The symbols come from the single
// shared subtract and compare unit, which walks the remaining idle time down by
// one symbol in each cycle that the output stage can take one. A burst stops
// emitting once symbol_capacity symbols have gone out; new_burst clears the
// count.
module step_pulse_symbol_encoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [spse_pkg::COUNT_W-1:0]    cfg_wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [spse_pkg::S_TDATA_W-1:0]  s_tdata,  // period_ticks[21:0], zero pad
	input  logic                            s_tuser,  // new_burst
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [spse_pkg::M_TDATA_W-1:0]  m_tdata,  // first_duration[14:0],
	                                                  // second_duration[29:15],
	                                                  // symbol_index[45:30], zero pad
	output logic                            m_tuser,  // pulse_level
	output logic                            m_tlast   // last_of_step
);
	import spse_pkg::*;

	localparam logic [PERIOD_W-1:0] H1      = PERIOD_W'(HALF_DURATION_MAX);
	localparam logic [PERIOD_W-1:0] H2      = PERIOD_W'(2 * HALF_DURATION_MAX);
	localparam logic [PERIOD_W-1:0] PMAX    = PERIOD_W'(PERIOD_MAX);
	localparam logic [PERIOD_W-1:0] PULSE_P = PERIOD_W'(PULSE_HIGH_LEN);

	state_t                state_q, state_d;
	logic [COUNT_W-1:0]    cap_q;
	logic [COUNT_W-1:0]    count_q;
	logic [PERIOD_W-1:0]   idle_q;

	logic                  out_valid_q;
	logic                  out_level_q;
	logic [DUR_W-1:0]      out_d0_q;
	logic [DUR_W-1:0]      out_d1_q;
	logic [COUNT_W-1:0]    out_idx_q;
	logic                  out_last_q;

	logic                  in_accept;
	logic                  emit_go;
	logic [PERIOD_W-1:0]   period_c;
	logic [COUNT_W-1:0]    count_start;
	logic                  start_blocked;

	logic                  sym_level;
	logic [PERIOD_W-1:0]   sym_d0;
	logic [PERIOD_W-1:0]   sym_d1;
	logic                  sym_done;
	logic [PERIOD_W-1:0]   idle_next;
	logic                  cap_hit;
	logic [COUNT_W:0]      count_inc;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign emit_go   = (state_q != ST_IDLE) && (!out_valid_q || m_tready);

	assign period_c      = (s_tdata[PERIOD_W-1:0] > PMAX) ? PMAX : s_tdata[PERIOD_W-1:0];
	assign count_start   = s_tuser ? '0 : count_q;
	assign start_blocked = (count_start >= cap_q);

	assign count_inc = {1'b0, count_q} + {{COUNT_W{1'b0}}, 1'b1};
	assign cap_hit   = (count_inc >= {1'b0, cap_q});

	// shared subtract and compare: symbol for the current phase
	always_comb begin
		sym_level = 1'b0;
		sym_d0    = '0;
		sym_d1    = '0;
		sym_done  = 1'b1;
		idle_next = idle_q;
		case (state_q)
			ST_SHORT: begin
				sym_level = 1'b1;
				sym_d0    = idle_q;
			end
			ST_PULSE: begin
				sym_level = 1'b1;
				sym_d0    = PULSE_P;
				if (idle_q <= H1) begin
					sym_d1 = idle_q;
				end else begin
					sym_d1    = H1;
					sym_done  = 1'b0;
					idle_next = idle_q - H1;
				end
			end
			ST_BULK: begin
				if (idle_q > H2) begin
					sym_d0    = H1;
					sym_d1    = H1;
					sym_done  = 1'b0;
					idle_next = idle_q - H2;
				end else if (idle_q > H1) begin
					sym_d0 = H1;
					sym_d1 = idle_q - H1;
				end else begin
					sym_d0 = idle_q;
				end
			end
			default: begin
				sym_done = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && !start_blocked) begin
					state_d = (period_c <= PULSE_P) ? ST_SHORT : ST_PULSE;
				end
			end
			ST_SHORT, ST_PULSE, ST_BULK: begin
				if (emit_go) begin
					if (sym_done || cap_hit) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_BULK;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= '1;
			count_q     <= '0;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (in_accept) begin
				count_q <= count_start;
				idle_q  <= (period_c <= PULSE_P) ? period_c : period_c - PULSE_P;
			end else if (emit_go) begin
				count_q <= count_inc[COUNT_W-1:0];
				idle_q  <= sym_done ? '0 : idle_next;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, loaded with each new symbol
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_level_q <= sym_level;
			out_d0_q    <= sym_d0[DUR_W-1:0];
			out_d1_q    <= sym_d1[DUR_W-1:0];
			out_idx_q   <= count_q;
			out_last_q  <= sym_done || cap_hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_level_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(M_TDATA_W - 2 * DUR_W - COUNT_W){1'b0}}, out_idx_q, out_d1_q, out_d0_q};

endmodule

FILE: tb/sv/tb_top.sv
// testbench for the step pulse symbol encoder: random and corner step requests, scoreboard check
`timescale 1ns / 1ps

module tb_top;
	import spse_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int DIRECTED_COUNT = 20;
	localparam int PHASE_COUNT    = 8;

	typedef struct packed {
		logic               level;
		logic [DUR_W-1:0]   first_dur;
		logic [DUR_W-1:0]   second_dur;
		logic [COUNT_W-1:0] index;
		logic               last;
	} symbol_t;

	class symbol_scoreboard;
		logic [COUNT_W-1:0] capacity;
		logic [COUNT_W-1:0] emitted;
		symbol_t            step_q[$];
		symbol_t            expected_q[$];
		int                 errors;
		int                 symbols_checked;
		int                 steps_noted;

		function new();
			capacity = '1;
			emitted  = '0;
		endfunction

		function void set_capacity(logic [COUNT_W-1:0] value);
			capacity = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// one symbol into the current step, refused once the burst is full or the step holds 64 symbols
		function bit push_symbol(logic level, int unsigned d0, int unsigned d1);
			symbol_t sym;
			if (emitted >= capacity || step_q.size() >= 64)
				return 1'b0;
			sym.level      = level;
			sym.first_dur  = DUR_W'(d0);
			sym.second_dur = DUR_W'(d1);
			sym.index      = emitted;
			sym.last       = 1'b0;
			step_q.push_back(sym);
			emitted = emitted + 1'b1;
			return 1'b1;
		endfunction

		function void note_request(logic [PERIOD_W-1:0] period_in, logic burst_start);
			int unsigned period;
			int unsigned idle;
			step_q.delete();
			steps_noted++;
			if (burst_start)
				emitted = '0;
			period = 32'(period_in);
			if (period > PERIOD_MAX)
				period = PERIOD_MAX;
			if (period <= PULSE_HIGH_LEN) begin
				void'(push_symbol(1'b1, period, 0));
			end else begin
				idle = period - PULSE_HIGH_LEN;
				if (idle <= HALF_DURATION_MAX) begin
					void'(push_symbol(1'b1, PULSE_HIGH_LEN, idle));
				end else if (push_symbol(1'b1, PULSE_HIGH_LEN, HALF_DURATION_MAX)) begin
					idle -= HALF_DURATION_MAX;
					while (idle > 2 * HALF_DURATION_MAX &&
						push_symbol(1'b0, HALF_DURATION_MAX, HALF_DURATION_MAX))
						idle -= 2 * HALF_DURATION_MAX;
					// a full buffer leaves the bulk loop early and skips the fragment
					if (idle <= 2 * HALF_DURATION_MAX) begin
						if (idle > HALF_DURATION_MAX)
							void'(push_symbol(1'b0, HALF_DURATION_MAX, idle - HALF_DURATION_MAX));
						else
							void'(push_symbol(1'b0, idle, 0));
					end
				end
			end
			if (step_q.size() > 0)
				step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[i])
				expected_q.push_back(step_q[i]);
		endfunction

		function void check_symbol(symbol_t got);
			symbol_t want;
			symbols_checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected symbol: lvl=%0d d0=%0d d1=%0d idx=%0d last=%0d",
						got.level, got.first_dur, got.second_dur, got.index, got.last);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				errors++;
				// fields as lvl/d0/d1/idx/last
				if (errors <= 10)
					$display("mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
						want.level, want.first_dur, want.second_dur, want.index, want.last,
						got.level, got.first_dur, got.second_dur, got.index, got.last);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [COUNT_W-1:0]   cfg_wr_data = '0;
	logic                 s_tvalid    = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata     = '0;
	logic                 s_tuser     = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready    = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	symbol_scoreboard sb;
	int               idle_cycles = 0;
	int               cfg_writes  = 0;

	step_pulse_symbol_encoder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sink ready pattern: runs of always ready, coin flip, sparse, and long stalls
	initial begin : sink_pattern
		int mode;
		int run;
		int pos;
		forever begin
			mode = $urandom_range(0, 3);
			run  = $urandom_range(32, 400);
			for (pos = 0; pos < run; pos++) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((pos % 16) < 12) ? 1'b0 : 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		symbol_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.level      = m_tuser;
			got.first_dur  = m_tdata[14:0];
			got.second_dur = m_tdata[29:15];
			got.index      = m_tdata[45:30];
			got.last       = m_tlast;
			sb.check_symbol(got);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("FAIL step_pulse_symbol_encoder_unit");
			$finish;
		end
	end

	task automatic send_request(logic [PERIOD_W-1:0] period, logic burst_start);
		s_tdata  <= {{(S_TDATA_W - PERIOD_W){1'b0}}, period};
		s_tuser  <= burst_start;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(period, burst_start);
	endtask

	// block must be idle before the register changes
	task automatic settle_and_configure(logic [COUNT_W-1:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		sb.set_capacity(value);
		cfg_writes++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [PERIOD_W-1:0] directed_period(int i);
		case (i)
			0:  return 22'd0;
			1:  return 22'd1;
			2:  return 22'd2;
			3:  return 22'd3;
			4:  return 22'(HALF_DURATION_MAX + 1);
			5:  return 22'(HALF_DURATION_MAX + 2);
			6:  return 22'(HALF_DURATION_MAX + 3);
			7:  return 22'(2 * HALF_DURATION_MAX + 2);
			8:  return 22'(2 * HALF_DURATION_MAX + 3);
			9:  return 22'(3 * HALF_DURATION_MAX + 1);
			10: return 22'(3 * HALF_DURATION_MAX + 2);
			11: return 22'(3 * HALF_DURATION_MAX + 3);
			12: return 22'(PERIOD_MAX - 1);
			13: return 22'(PERIOD_MAX);
			14: return 22'(PERIOD_MAX + 1);
			15: return 22'h3FFFFF;
			16: return 22'h2AAAAA;
			17: return 22'h155555;
			18: return 22'd2;
			default: return 22'd100;
		endcase
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period();
		int unsigned k;
		k = $urandom_range(1, 128);
		case ($urandom_range(0, 9))
			0: return 22'($urandom_range(0, 3));
			// just around the pulse length plus a multiple of the half duration
			1: return 22'(PULSE_HIGH_LEN + HALF_DURATION_MAX * k - 1 + $urandom_range(0, 2));
			2: return 22'($urandom_range(PERIOD_MAX, 22'h3FFFFF));
			3, 4: return 22'($urandom_range(0, 22'h3FFFFF));
			default: return 22'($urandom_range(3, 200000));
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] phase_capacity(int p);
		case (p)
			0: return 16'hFFFF;
			1: return 16'd0;
			2: return 16'd1;
			3: return 16'd3;
			4: return 16'd64;
			5: return 16'($urandom_range(2, 500));
			6: return 16'hFFFE;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic run_random(int count);
		int burst_left;
		burst_left = $urandom_range(1, 8);
		for (int i = 0; i < count; i++) begin
			// one full drain in the middle of every phase
			if (i == count / 2) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_request(pick_period(), (i == 0) ? 1'($urandom_range(0, 1))
				: ($urandom_range(0, 7) == 0));
			burst_left--;
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner periods at the reset capacity
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_request(directed_period(i), (i == 0 || i == 18));
		s_tvalid <= 1'b0;
		@(posedge clk);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle_and_configure(phase_capacity(p));
			run_random((p == 1) ? 12 : 40);
		end

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d step requests over %0d capacity settings, %0d symbols checked",
			sb.steps_noted, cfg_writes, sb.symbols_checked);
		$display("mismatches: %0d, symbols still awaited: %0d", sb.errors, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS step_pulse_symbol_encoder_unit");
		end else begin
			$display("FAIL step_pulse_symbol_encoder_unit");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/spse_pkg.sv
hdl/step_pulse_symbol_encoder_unit.sv
tb/sv/tb_top.sv
